// ===== design/qsv_pkg.sv =====
package qsv_pkg;

	localparam int unsigned NQ_DEFAULT    = 10;
	localparam int unsigned BATCH_DEFAULT = 16;
	localparam int unsigned PROB_W        = 17;
	localparam int unsigned PROB_MAX      = 65536;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	typedef enum logic [2:0] {
		OP_RESET = 3'd0,
		OP_MAT   = 3'd1,
		OP_X     = 3'd2,
		OP_Y     = 3'd3,
		OP_Z     = 3'd4,
		OP_CNOT  = 3'd5,
		OP_CZ    = 3'd6,
		OP_QUERY = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		JOB_CLEAR,
		JOB_MAT,
		JOB_X,
		JOB_Y,
		JOB_Z,
		JOB_CNOT,
		JOB_CZ,
		JOB_QUERY,
		JOB_NONE
	} job_kind_t;

	typedef struct packed {
		job_kind_t                kind;
		logic                     status;
		logic [3:0]               tq;
		logic [3:0]               cq;
		logic [9:0]               idx;
		logic signed [7:0][15:0]  m;
	} job_t;

	typedef struct packed {
		logic init;
	} back_stat_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_RD0,
		ST_RD1,
		ST_LD1,
		ST_PROD,
		ST_SUM,
		ST_WR0,
		ST_WR1,
		ST_QRD,
		ST_QSQ,
		ST_QACC,
		ST_DIV,
		ST_FIN
	} st_t;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767)
			r = 16'sd32767;
		else if (v < -20'sd32768)
			r = -16'sd32768;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
		logic signed [16:0] n;
		n = -{v[15], v};
		return sat16({{3{n[16]}}, n});
	endfunction

	// Q2.28 sum to Q1.14: add half an LSB, floor shift, saturate.
	function automatic logic signed [15:0] round_q28(input logic signed [33:0] x);
		logic signed [33:0] b;
		b = (x + 34'sd8192) >>> 14;
		return sat16(b[19:0]);
	endfunction

endpackage

// ===== design/qsv_cmd_if.sv =====
interface qsv_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic [3:0]         target_qubit;
	logic [3:0]         control_qubit;
	logic [9:0]         basis_index;
	logic signed [15:0] m00_re;
	logic signed [15:0] m00_im;
	logic signed [15:0] m01_re;
	logic signed [15:0] m01_im;
	logic signed [15:0] m10_re;
	logic signed [15:0] m10_im;
	logic signed [15:0] m11_re;
	logic signed [15:0] m11_im;

	modport source (output valid, op, target_qubit, control_qubit, basis_index,
		m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im, input ready);
	modport sink (input valid, op, target_qubit, control_qubit, basis_index,
		m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im, output ready);
endinterface

// ===== design/qsv_rsp_if.sv =====
interface qsv_rsp_if;
	logic        valid;
	logic        ready;
	logic [16:0] probability;
	logic        status;

	modport source (output valid, probability, status, input ready);
	modport sink (input valid, probability, status, output ready);
endinterface

// ===== design/qsv_ram.sv =====
module qsv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/qsv_front.sv =====
module qsv_front import qsv_pkg::*; #(
	parameter int unsigned NQ = NQ_DEFAULT
) (
	qsv_cmd_if.sink    cmd,
	input  back_stat_t stat,
	input  logic       q_full,
	output logic       q_push,
	output job_t       q_job
);
	logic tq_bad, cq_bad, idx_bad;

	assign tq_bad  = {1'b0, cmd.target_qubit} >= 5'(NQ);
	assign cq_bad  = {1'b0, cmd.control_qubit} >= 5'(NQ);
	assign idx_bad = 32'(cmd.basis_index) >= (32'd1 << NQ);

	// hold off during the power-up clearing pass
	assign cmd.ready = !q_full && !stat.init;
	assign q_push    = cmd.valid && cmd.ready;

	always_comb begin
		q_job.tq     = cmd.target_qubit;
		q_job.cq     = cmd.control_qubit;
		q_job.idx    = cmd.basis_index;
		q_job.m      = {cmd.m11_im, cmd.m11_re, cmd.m10_im, cmd.m10_re,
			cmd.m01_im, cmd.m01_re, cmd.m00_im, cmd.m00_re};
		q_job.status = 1'b0;
		q_job.kind   = JOB_NONE;
		case (op_t'(cmd.op))
			OP_RESET: q_job.kind = JOB_CLEAR;
			OP_MAT:   q_job.kind = JOB_MAT;
			OP_X:     q_job.kind = JOB_X;
			OP_Y:     q_job.kind = JOB_Y;
			OP_Z:     q_job.kind = JOB_Z;
			OP_CNOT:  q_job.kind = JOB_CNOT;
			OP_CZ:    q_job.kind = JOB_CZ;
			OP_QUERY: q_job.kind = JOB_QUERY;
			default:  q_job.kind = JOB_NONE;
		endcase
		case (op_t'(cmd.op))
			OP_MAT, OP_X, OP_Y, OP_Z: q_job.status = tq_bad;
			OP_CNOT, OP_CZ: q_job.status = tq_bad || cq_bad ||
				(cmd.target_qubit == cmd.control_qubit);
			OP_QUERY: q_job.status = idx_bad;
			default:  q_job.status = 1'b0;
		endcase
		// drop bad commands to a status-only job
		if (q_job.status)
			q_job.kind = JOB_NONE;
	end
endmodule

// ===== design/qsv_queue.sv =====
module qsv_queue import qsv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t pop_job
);
	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign avail   = cnt_q != 2'd0;
	assign pop_job = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== design/qsv_back.sv =====
module qsv_back import qsv_pkg::*; #(
	parameter int unsigned NQ    = NQ_DEFAULT,
	parameter int unsigned BATCH = BATCH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_avail,
	input  job_t       job,
	output logic       pop,
	output back_stat_t stat,
	qsv_rsp_if.source  rsp
);
	localparam int unsigned DEPTH = (2 ** NQ) * BATCH;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned SW    = (BATCH > 1) ? $clog2(BATCH) : 1;
	localparam int unsigned NUMW  = 34 + $clog2(BATCH);
	localparam logic [NUMW-1:0] HALF    = NUMW'(BATCH * 2048);
	localparam logic [NUMW-1:0] SAT_N   = NUMW'(65537 * BATCH);
	localparam logic [33:0]     M_RECIP = 34'(((longint'(1) << 33) + longint'(BATCH) - 1)
		/ longint'(BATCH));
	localparam logic [16:0]     M_LO    = M_RECIP[16:0];
	localparam logic [16:0]     M_HI    = M_RECIP[33:17];

	st_t st_q, st_d;

	job_t                     job_q;
	logic                     init_q;
	logic [NQ-1:0]            i_q;
	logic [SW-1:0]            s_q;
	logic [AW-1:0]            clr_q;
	logic signed [15:0]       a0r_q, a0i_q, a1r_q, a1i_q;
	logic signed [15:0]       n0r_q, n0i_q, n1r_q, n1i_q;
	logic signed [31:0]       prod_q [16];
	logic [31:0]              sqr_q, sqi_q;
	logic [NUMW-1:0]          acc_q, quo_q;
	logic [41:0]              plo_q, phi_q;
	logic                     sat_q;
	logic [1:0]               dcnt_q;
	logic                     res_valid_q;
	logic [PROB_W-1:0]        prob_q;
	logic                     status_q;

	logic [NQ-1:0]  tm, cm;
	logic           two_q, qual, i_last, s_last;
	logic [AW-1:0]  addr0, addr1, qaddr;
	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic [31:0]    wdata, rdata;
	logic           res_free;
	logic [24:0]    num25;
	logic [58:0]    psum;

	qsv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign tm     = NQ'(1) << job_q.tq;
	assign cm     = NQ'(1) << job_q.cq;
	assign two_q  = (job_q.kind == JOB_CNOT) || (job_q.kind == JOB_CZ);
	assign qual   = ((i_q & tm) == '0) && (!two_q || ((i_q & cm) != '0));
	assign i_last = i_q == {NQ{1'b1}};
	assign s_last = 32'(s_q) == BATCH - 1;
	assign addr0  = AW'(i_q) * AW'(BATCH) + AW'(s_q);
	assign addr1  = AW'(i_q | tm) * AW'(BATCH) + AW'(s_q);
	assign qaddr  = AW'(job_q.idx) * AW'(BATCH) + AW'(s_q);
	assign res_free = !res_valid_q || rsp.ready;
	assign num25  = 25'(quo_q >> 12);
	assign psum   = {phi_q, 17'd0} + {17'd0, plo_q};

	assign stat.init       = init_q;
	assign rsp.valid       = res_valid_q;
	assign rsp.probability = prob_q;
	assign rsp.status      = status_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLR:
				if (32'(clr_q) == DEPTH - 1)
					st_d = init_q ? ST_IDLE : ST_FIN;
			ST_IDLE:
				if (job_avail) begin
					case (job.kind)
						JOB_CLEAR: st_d = ST_CLR;
						JOB_QUERY: st_d = ST_QRD;
						JOB_NONE:  st_d = ST_FIN;
						default:   st_d = ST_SCAN;
					endcase
				end
			ST_SCAN:
				if (qual)
					st_d = ST_RD0;
				else if (i_last)
					st_d = ST_FIN;
			ST_RD0:  st_d = ST_RD1;
			ST_RD1:  st_d = ST_LD1;
			ST_LD1:  st_d = ST_PROD;
			ST_PROD: st_d = ST_SUM;
			ST_SUM:  st_d = ST_WR0;
			ST_WR0:  st_d = ST_WR1;
			ST_WR1:
				if (!s_last)
					st_d = ST_RD0;
				else
					st_d = i_last ? ST_FIN : ST_SCAN;
			ST_QRD:  st_d = ST_QSQ;
			ST_QSQ:  st_d = ST_QACC;
			ST_QACC: st_d = s_last ? ST_DIV : ST_QRD;
			ST_DIV:
				if (dcnt_q == 2'd2)
					st_d = ST_FIN;
			ST_FIN:
				if (res_free)
					st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// memory port and queue control
	always_comb begin
		we    = 1'b0;
		waddr = addr0;
		wdata = {n0r_q, n0i_q};
		raddr = addr0;
		pop   = 1'b0;
		case (st_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (32'(clr_q) < BATCH) ? {ONE_Q14, 16'sd0} : '0;
			end
			ST_IDLE: pop = job_avail;
			ST_RD1:  raddr = addr1;
			ST_WR0:  we = 1'b1;
			ST_WR1: begin
				we    = 1'b1;
				waddr = addr1;
				wdata = {n1r_q, n1i_q};
			end
			ST_QRD:  raddr = qaddr;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			init_q      <= 1'b1;
			res_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLR) begin
				if (32'(clr_q) == DEPTH - 1) begin
					clr_q  <= '0;
					init_q <= 1'b0;
				end else begin
					clr_q <= clr_q + AW'(1);
				end
			end
			if (st_q == ST_FIN && res_free)
				res_valid_q <= 1'b1;
			else if (rsp.ready)
				res_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				job_q <= job;
				i_q   <= '0;
				s_q   <= '0;
				acc_q <= '0;
			end
			ST_SCAN:
				if (!qual && !i_last)
					i_q <= i_q + NQ'(1);
			ST_RD1: {a0r_q, a0i_q} <= rdata;
			ST_LD1: {a1r_q, a1i_q} <= rdata;
			ST_PROD: begin
				prod_q[0]  <= $signed(job_q.m[0]) * a0r_q;
				prod_q[1]  <= $signed(job_q.m[1]) * a0i_q;
				prod_q[2]  <= $signed(job_q.m[2]) * a1r_q;
				prod_q[3]  <= $signed(job_q.m[3]) * a1i_q;
				prod_q[4]  <= $signed(job_q.m[0]) * a0i_q;
				prod_q[5]  <= $signed(job_q.m[1]) * a0r_q;
				prod_q[6]  <= $signed(job_q.m[2]) * a1i_q;
				prod_q[7]  <= $signed(job_q.m[3]) * a1r_q;
				prod_q[8]  <= $signed(job_q.m[4]) * a0r_q;
				prod_q[9]  <= $signed(job_q.m[5]) * a0i_q;
				prod_q[10] <= $signed(job_q.m[6]) * a1r_q;
				prod_q[11] <= $signed(job_q.m[7]) * a1i_q;
				prod_q[12] <= $signed(job_q.m[4]) * a0i_q;
				prod_q[13] <= $signed(job_q.m[5]) * a0r_q;
				prod_q[14] <= $signed(job_q.m[6]) * a1i_q;
				prod_q[15] <= $signed(job_q.m[7]) * a1r_q;
			end
			ST_SUM: begin
				case (job_q.kind)
					JOB_MAT: begin
						n0r_q <= round_q28(34'(prod_q[0]) - 34'(prod_q[1])
							+ 34'(prod_q[2]) - 34'(prod_q[3]));
						n0i_q <= round_q28(34'(prod_q[4]) + 34'(prod_q[5])
							+ 34'(prod_q[6]) + 34'(prod_q[7]));
						n1r_q <= round_q28(34'(prod_q[8]) - 34'(prod_q[9])
							+ 34'(prod_q[10]) - 34'(prod_q[11]));
						n1i_q <= round_q28(34'(prod_q[12]) + 34'(prod_q[13])
							+ 34'(prod_q[14]) + 34'(prod_q[15]));
					end
					JOB_X, JOB_CNOT: begin
						{n0r_q, n0i_q} <= {a1r_q, a1i_q};
						{n1r_q, n1i_q} <= {a0r_q, a0i_q};
					end
					JOB_Y: begin
						n0r_q <= a1i_q;
						n0i_q <= neg16(a1r_q);
						n1r_q <= neg16(a0i_q);
						n1i_q <= a0r_q;
					end
					default: begin
						{n0r_q, n0i_q} <= {a0r_q, a0i_q};
						n1r_q <= neg16(a1r_q);
						n1i_q <= neg16(a1i_q);
					end
				endcase
			end
			ST_WR1: begin
				if (!s_last)
					s_q <= s_q + SW'(1);
				else begin
					s_q <= '0;
					if (!i_last)
						i_q <= i_q + NQ'(1);
				end
			end
			ST_QSQ: begin
				sqr_q <= 32'($signed(rdata[31:16]) * $signed(rdata[31:16]));
				sqi_q <= 32'($signed(rdata[15:0]) * $signed(rdata[15:0]));
			end
			ST_QACC: begin
				acc_q <= acc_q + NUMW'(sqr_q) + NUMW'(sqi_q);
				s_q   <= s_q + SW'(1);
				if (s_last) begin
					quo_q  <= acc_q + NUMW'(sqr_q) + NUMW'(sqi_q) + HALF;
					dcnt_q <= '0;
				end
			end
			ST_DIV: begin
				// drop the 4096 by shift, then scale by the reciprocal of BATCH
				// in two partial products
				dcnt_q <= dcnt_q + 2'd1;
				if (dcnt_q == 2'd0) begin
					sat_q <= (quo_q >> 12) >= SAT_N;
					plo_q <= 42'(num25) * 42'(M_LO);
				end else if (dcnt_q == 2'd1) begin
					phi_q <= 42'(num25) * 42'(M_HI);
				end else begin
					quo_q <= NUMW'(psum >> 33);
				end
			end
			ST_FIN:
				if (res_free) begin
					status_q <= job_q.status;
					prob_q   <= (job_q.kind == JOB_QUERY)
						? (sat_q ? PROB_W'(PROB_MAX) : quo_q[PROB_W-1:0]) : '0;
				end
			default: job_q <= job_q;
		endcase
	end
endmodule

// ===== design/qubit_state_vector_gate_engine_core.sv =====
// channel | dir | handshake   | payload
// cmd     | in  | valid/ready | op, target_qubit, control_qubit, basis_index, m00..m11 re/im
// rsp     | out | valid/ready | probability, status
//
// One result per command, in command order. A gate sweeps every basis index once
// and steps each amplitude pair through RD0, RD1, LD1, PROD, SUM, WR0 and WR1 on
// the single RAM port pair (CNOT/CZ visit half as many pairs). A query reads the
// BATCH slots of one index; a reset command reloads the zero state in every word.
// After arst_n a clearing pass over all 2^NQ*BATCH words loads the zero state; cmd.ready
// stays low until it ends. A two-entry queue parts front and back; a held result
// stalls the back only when the next one is ready to leave.
module qubit_state_vector_gate_engine_core import qsv_pkg::*; #(
	parameter int unsigned NQ    = NQ_DEFAULT,
	parameter int unsigned BATCH = BATCH_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	qsv_cmd_if.sink   cmd,
	qsv_rsp_if.source rsp
);
	logic       q_push, q_full, q_avail, q_pop;
	job_t       push_job, pop_job;
	back_stat_t stat;

	// classify and validate each transfer
	qsv_front #(.NQ(NQ)) u_front (
		.cmd   (cmd),
		.stat  (stat),
		.q_full(q_full),
		.q_push(q_push),
		.q_job (push_job)
	);

	// hold up to two classified jobs
	qsv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (q_pop),
		.avail   (q_avail),
		.pop_job (pop_job)
	);

	// sweep the state memory and deliver results
	qsv_back #(.NQ(NQ), .BATCH(BATCH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_avail(q_avail),
		.job      (pop_job),
		.pop      (q_pop),
		.stat     (stat),
		.rsp      (rsp)
	);
endmodule

// ===== design/qsv_checker.sv =====
module qsv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [16:0] rsp_probability,
	input logic        rsp_status
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_hold_prob: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_probability))
		else $error("probability changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_probability == 17'd0)
		else $error("error result carries a probability");

	a_prob_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_probability <= 17'd65536)
		else $error("probability above saturation");
endmodule

bind qubit_state_vector_gate_engine_core qsv_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_probability(rsp.probability),
	.rsp_status     (rsp.status)
);
